// ===== hdl/ibcs_pkg.sv =====
// Package for the southbridge configuration space block.
// Holds codes, variant helpers and the power-on table functions; no dependencies.
`timescale 1ns / 1ps
package ibcs_pkg;

  localparam int unsigned RegBytes = 256;
  localparam int unsigned AddrW    = 8;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_HRST  = 2'd2;

  localparam logic [1:0] VAR_FIRST = 2'd0;
  localparam logic [1:0] VAR_LATER = 2'd1;
  localparam logic [1:0] VAR_NOIDE = 2'd2;

  localparam logic [2:0] FN_BRIDGE = 3'd0;
  localparam logic [2:0] FN_IDE    = 3'd1;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CLEAR = 2'd1,
    ST_READ  = 2'd2,
    ST_SEND  = 2'd3
  } state_t;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] function_number;
    logic [7:0] reg_address;
    logic [7:0] write_data;
    logic       mouse_scan_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        ide_primary_on;
    logic        ide_secondary_on;
    logic [15:0] bus_master_base;
    logic        bus_master_on;
    logic        route_valid;
    logic [2:0]  route_line;
    logic        route_disabled;
    logic [3:0]  route_irq;
    logic        dma_alias_on;
    logic        mouse_scan_out;
  } out_beat_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clr_step;   // write power-on value at clear address, advance
    logic clr_start;  // reset clear address
    logic capture;    // latch input beat, issue RAM reads
    logic execute;    // apply read data: write back, form result
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
  } dp_sts_t;

  // Power-on value of a bridge byte for variant v.
  function automatic logic [7:0] bridge_init(input logic [1:0] v, input logic [7:0] a);
    logic later;
    logic nide;
    logic [7:0] r;
    later = (v == VAR_LATER);
    nide  = (v == VAR_NOIDE);
    unique case (a)
      8'h00: r = 8'h86;
      8'h01: r = 8'h80;
      8'h02: r = later ? 8'h00 : 8'h2e;
      8'h03: r = later ? 8'h70 : 8'h12;
      8'h04: r = nide ? 8'h06 : 8'h07;
      8'h06: r = 8'h80;
      8'h07: r = 8'h02;
      8'h08: r = nide ? 8'h02 : 8'h00;
      8'h0a: r = 8'h01;
      8'h0b: r = 8'h06;
      8'h0e: r = nide ? 8'h00 : 8'h80;
      8'h4c: r = 8'h4d;
      8'h4e: r = 8'h03;
      8'h60, 8'h61, 8'h62, 8'h63: r = 8'h80;
      8'h69: r = 8'h02;
      8'h70: r = 8'hc0;
      8'h71: r = later ? 8'h00 : 8'hc0;
      8'h76, 8'h77: r = 8'h0c;
      8'h78: r = 8'h02;
      8'ha0: r = 8'h08;
      8'ha8: r = 8'h0f;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ide_init(input logic [1:0] v, input logic [7:0] a);
    logic later;
    logic [7:0] r;
    later = (v == VAR_LATER);
    unique case (a)
      8'h00: r = 8'h86;
      8'h01: r = 8'h80;
      8'h02: r = later ? 8'h10 : 8'h30;
      8'h03: r = later ? 8'h70 : 8'h12;
      8'h04: r = 8'h03;
      8'h06: r = 8'h80;
      8'h07: r = 8'h02;
      8'h09: r = 8'h80;
      8'h0a: r = 8'h01;
      8'h0b: r = 8'h01;
      8'h20: r = 8'h01;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/ibcs_if.sv =====
// Valid/ready channel interface carrying one payload beat.
// Payload type is given as a parameter; no package dependency.
`timescale 1ns / 1ps
interface ibcs_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/ibcs_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ibcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/ibcs_ctrl.sv =====
// Controller state machine for the configuration space block.
// Depends on ibcs_pkg.
`timescale 1ns / 1ps
module ibcs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_is_hrst,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ibcs_pkg::dp_cmd_t cmd,
  input  ibcs_pkg::dp_sts_t sts
);
  ibcs_pkg::state_t state_r, state_nxt;
  logic             pend_r, pend_nxt;  // hard reset owes a result after clearing

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ibcs_pkg::ST_CLEAR;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ibcs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_is_hrst) begin
            cmd.clr_start = 1'b1;
            pend_nxt      = 1'b1;
            state_nxt     = ibcs_pkg::ST_CLEAR;
          end else begin
            state_nxt = ibcs_pkg::ST_READ;
          end
        end
      end
      ibcs_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          if (pend_r) begin
            cmd.execute = 1'b1;
            pend_nxt    = 1'b0;
            state_nxt   = ibcs_pkg::ST_SEND;
          end else begin
            state_nxt = ibcs_pkg::ST_IDLE;
          end
        end
      end
      ibcs_pkg::ST_READ: begin
        cmd.execute = 1'b1;
        state_nxt   = ibcs_pkg::ST_SEND;
      end
      ibcs_pkg::ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ibcs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ibcs_pkg::ST_IDLE;
    endcase
  end
endmodule

// ===== hdl/ibcs_dp.sv =====
// Datapath: both register RAMs, write filters, read masks and result register.
// Depends on ibcs_pkg and ibcs_ram.
`timescale 1ns / 1ps
module ibcs_dp #(
  parameter int unsigned REG_BYTES = ibcs_pkg::RegBytes
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          chip_variant,
  input  ibcs_pkg::in_beat_t  in_beat,
  input  ibcs_pkg::dp_cmd_t   cmd,
  output ibcs_pkg::dp_sts_t   sts,
  output ibcs_pkg::out_beat_t out_beat
);
  localparam int unsigned AW = $clog2(REG_BYTES);

  ibcs_pkg::in_beat_t     beat_r;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic                   alias_r, mouse_r;
  logic                   ide_en_r, pri_r, sec_r;
  logic [7:0]             bm_lo_r, bm_hi_r;
  ibcs_pkg::out_beat_t    res_r;

  logic                   b_we, d_we;
  logic [AW-1:0]          b_addr, d_addr;
  logic [7:0]             b_wd, d_wd, b_rd, d_rd;

  logic later, nide, ide_ok;
  logic [7:0] a, v, rd;
  logic       bw_en, dw_en, alias_nxt, mouse_nxt;
  logic [7:0] bw_val, dw_val;
  logic       rv;
  logic [2:0] rline;

  assign later  = (chip_variant == ibcs_pkg::VAR_LATER);
  assign nide   = (chip_variant == ibcs_pkg::VAR_NOIDE);
  assign a      = beat_r.reg_address;
  assign v      = beat_r.write_data;
  assign ide_ok = (beat_r.function_number == ibcs_pkg::FN_IDE) && !nide;

  ibcs_ram #(.WIDTH(8), .DEPTH(REG_BYTES)) u_bridge (
    .clk(clk), .we(b_we), .addr(b_addr), .wdata(b_wd), .rdata(b_rd)
  );
  ibcs_ram #(.WIDTH(8), .DEPTH(REG_BYTES)) u_ide (
    .clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wd), .rdata(d_rd)
  );

  // Read masking and write filtering, computed from the RAM read data.
  always_comb begin
    rd        = 8'h00;
    bw_en     = 1'b0;
    bw_val    = v;
    dw_en     = 1'b0;
    dw_val    = v;
    alias_nxt = alias_r;
    mouse_nxt = mouse_r;
    rv        = 1'b0;
    rline     = 3'd0;
    if (beat_r.op == ibcs_pkg::OP_READ) begin
      if (beat_r.function_number == ibcs_pkg::FN_BRIDGE) begin
        if (a[7:2] == 6'h18) begin
          rd = b_rd & 8'h8F;
        end else begin
          unique case (a)
            8'h04: rd = (b_rd & 8'h80) | (nide ? 8'h0F : 8'h07);
            8'h05: rd = later ? (b_rd & 8'h01) : 8'h00;
            8'h06: rd = b_rd & 8'h80;
            8'h07: rd = later ? b_rd : (b_rd & (nide ? 8'h02 : 8'h3E));
            8'h4e: rd = (b_rd & 8'hEF) | {7'd0, beat_r.mouse_scan_in};
            8'h69: rd = b_rd & 8'hFE;
            8'h6a: rd = b_rd & (later ? 8'hD1 : 8'h07);
            8'h6b: rd = later ? (b_rd & 8'h80) : 8'h00;
            8'h70: rd = b_rd & (later ? 8'hEF : 8'hCF);
            8'h71: rd = later ? 8'h00 : (b_rd & 8'hCF);
            8'h76, 8'h77: rd = b_rd & (later ? 8'h87 : 8'h8F);
            8'h80: rd = later ? (b_rd & 8'h7F) : 8'h00;
            8'h82: rd = later ? (b_rd & 8'h0F) : 8'h00;
            8'ha0: rd = b_rd & 8'h1F;
            8'ha3: rd = later ? (b_rd & 8'h01) : 8'h00;
            8'ha7: rd = later ? b_rd : (b_rd & 8'hEF);
            8'hab: rd = later ? b_rd : (b_rd & 8'hFE);
            default: rd = b_rd;
          endcase
        end
      end else if (ide_ok) begin
        unique case (a)
          8'h04: rd = (d_rd & 8'h05) | 8'h02;
          8'h05: rd = 8'h00;
          8'h06: rd = 8'h80;
          8'h07: rd = d_rd & 8'h3E;
          8'h0d: rd = d_rd & 8'hF0;
          8'h20: rd = (d_rd & 8'hF0) | 8'h01;
          8'h22, 8'h23: rd = 8'h00;
          8'h41, 8'h43: rd = d_rd & (later ? 8'hF3 : 8'hB3);
          default: rd = d_rd;
        endcase
      end else begin
        rd = 8'hFF;
      end
    end else if (beat_r.op == ibcs_pkg::OP_WRITE) begin
      if (beat_r.function_number == ibcs_pkg::FN_BRIDGE) begin
        if (!(a >= 8'h0f && a < 8'h4c)) begin
          bw_en = 1'b1;
          unique case (a)
            8'h00, 8'h01, 8'h02, 8'h03, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0e: bw_en = 1'b0;
            8'h4c: if (v != b_rd) alias_nxt = ~v[7];
            8'h4e: mouse_nxt = v[4];
            8'h60, 8'h61, 8'h62, 8'h63: begin
              rv    = 1'b1;
              rline = {1'b0, a[1:0]};
            end
            8'h6a: bw_val = later ? ((v & 8'hFD) | b_rd | 8'h02)
                                  : ((v & 8'hFC) | b_rd | 8'h03);
            8'h70: begin
              rv    = 1'b1;
              rline = 3'd4;
            end
            8'h71: if (chip_variant == ibcs_pkg::VAR_FIRST) begin
              rv    = 1'b1;
              rline = 3'd5;
            end
            default: ;
          endcase
        end
      end else if (ide_ok) begin
        unique case (a)
          8'h04: begin dw_en = 1'b1; dw_val = (v & 8'h05) | 8'h02; end
          8'h07: begin dw_en = 1'b1; dw_val = v & 8'h3E; end
          8'h0d, 8'h21, 8'h40, 8'h41, 8'h42, 8'h43: dw_en = 1'b1;
          8'h20: begin dw_en = 1'b1; dw_val = (v & 8'hF0) | 8'h01; end
          8'h44: dw_en = later;
          default: ;
        endcase
      end
    end
  end

  // RAM port steering: read address on capture, clearing sweep, or write-back on execute.
  always_comb begin
    b_addr = beat_r.reg_address[AW-1:0];
    d_addr = beat_r.reg_address[AW-1:0];
    b_wd   = bw_val;
    d_wd   = dw_val;
    b_we   = 1'b0;
    d_we   = 1'b0;
    clr_nxt = clr_r;
    if (cmd.capture) begin
      b_addr = in_beat.reg_address[AW-1:0];
      d_addr = in_beat.reg_address[AW-1:0];
    end
    if (cmd.clr_start) begin
      clr_nxt = '0;
    end else if (cmd.clr_step) begin
      b_addr  = clr_r;
      d_addr  = clr_r;
      b_wd    = ibcs_pkg::bridge_init(chip_variant, 8'(clr_r));
      d_wd    = ibcs_pkg::ide_init(chip_variant, 8'(clr_r));
      b_we    = 1'b1;
      d_we    = 1'b1;
      clr_nxt = clr_r + 1'b1;
    end else if (cmd.execute) begin
      b_we = bw_en;
      d_we = dw_en;
    end
  end

  assign sts.clr_done = (clr_r == AW'(REG_BYTES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r    <= '0;
      alias_r  <= 1'b1;
      mouse_r  <= 1'b0;
      ide_en_r <= 1'b1;
      pri_r    <= 1'b0;
      sec_r    <= 1'b0;
      bm_lo_r  <= 8'h01;
      bm_hi_r  <= 8'h00;
    end else begin
      clr_r <= clr_nxt;
      if (cmd.clr_step && sts.clr_done) begin
        ide_en_r <= 1'b1;
        pri_r    <= 1'b0;
        sec_r    <= 1'b0;
        bm_lo_r  <= 8'h01;
        bm_hi_r  <= 8'h00;
      end else if (cmd.execute && dw_en) begin
        if (a == 8'h04) ide_en_r <= dw_val[0];
        if (a == 8'h41) pri_r    <= dw_val[7];
        if (a == 8'h43) sec_r    <= dw_val[7];
        if (a == 8'h20) bm_lo_r  <= dw_val;
        if (a == 8'h21) bm_hi_r  <= dw_val;
      end
      if (cmd.execute) begin
        alias_r <= alias_nxt;
        mouse_r <= mouse_nxt;
      end
    end
  end

  // Result register; the IDE shadows are taken after this beat's write.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      beat_r <= in_beat;
    end
    if (cmd.execute) begin
      logic en, p, s;
      logic [7:0] lo, hi;
      en = ide_en_r; p = pri_r; s = sec_r; lo = bm_lo_r; hi = bm_hi_r;
      if (beat_r.op == ibcs_pkg::OP_HRST) begin
        en = 1'b1; p = 1'b0; s = 1'b0; lo = 8'h01; hi = 8'h00;
      end else if (dw_en) begin
        if (a == 8'h04) en = dw_val[0];
        if (a == 8'h41) p  = dw_val[7];
        if (a == 8'h43) s  = dw_val[7];
        if (a == 8'h20) lo = dw_val;
        if (a == 8'h21) hi = dw_val;
      end
      res_r.read_data        <= rd;
      res_r.ide_primary_on   <= !nide && en && p;
      res_r.ide_secondary_on <= !nide && en && s;
      res_r.bus_master_base  <= nide ? 16'h0000 : {hi, lo[7:4], 4'h0};
      res_r.bus_master_on    <= !nide && en;
      res_r.route_valid      <= rv;
      res_r.route_line       <= rline;
      res_r.route_disabled   <= rv && v[7];
      res_r.route_irq        <= (rv && !v[7]) ? v[3:0] : 4'h0;
      res_r.dma_alias_on     <= alias_nxt;
      res_r.mouse_scan_out   <= mouse_nxt;
    end
  end

  assign out_beat = res_r;
endmodule

// ===== hdl/isa_bridge_pci_config_space.sv =====
// Top level of the two-function southbridge configuration space.
// Depends on ibcs_pkg, ibcs_if, ibcs_ctrl, ibcs_dp and ibcs_ram.
//
//   Channel  Direction  Handshake      Content
//   in_      sink       valid/ready    op, function, address, write byte, mouse flag
//   out_     source     valid/ready    read byte and derived effects
//   cfg_     sink       write enable   chip variant
//
// A read or write is captured with its RAM reads issued, then executed on the
// read data; the result sits in the output register until it is taken. The
// single RAM port of each register file sets this sequence. After reset, and
// on every hard-reset access, a clearing sweep reloads all REG_BYTES bytes of
// the power-on tables one byte per cycle, while no input beat is accepted. A
// stall on the output holds the result and keeps the input side from accepting.
`timescale 1ns / 1ps
module isa_bridge_pci_config_space #(
  parameter int unsigned REG_BYTES = ibcs_pkg::RegBytes
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  ibcs_if.sink       in_ch,
  ibcs_if.source     out_ch
);
  logic [1:0]        variant_r;
  ibcs_pkg::dp_cmd_t cmd;
  ibcs_pkg::dp_sts_t sts;
  ibcs_pkg::in_beat_t in_beat;

  // The variant register; writing it does not reload the tables. The unused
  // code is kept as written: it behaves as the first generation everywhere
  // except that it never routes interrupt line 5, set through byte 0x71.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= ibcs_pkg::VAR_FIRST;
    end else if (cfg_we) begin
      variant_r <= cfg_wdata;
    end
  end

  assign in_beat = in_ch.payload;

  ibcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_is_hrst (in_beat.op == ibcs_pkg::OP_HRST),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  ibcs_dp #(.REG_BYTES(REG_BYTES)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .chip_variant (variant_r),
    .in_beat      (in_beat),
    .cmd          (cmd),
    .sts          (sts),
    .out_beat     (out_ch.payload)
  );
endmodule
